>>> rtl/sha1_pkg.sv
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } sha1_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } sha1_state_t;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          QUEUE_DEPTH = 2;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
            begin
                k = 32'h5A827999;
            end
            else if (r < 7'd40)
            begin
                k = 32'h6ED9EBA1;
            end
            else if (r < 7'd60)
            begin
                k = 32'h8F1BBCDC;
            end
            else
            begin
                k = 32'hCA62C1D6;
            end
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
            begin
                f = (b & c) | (~b & d);
            end
            else if (r >= 7'd40 && r < 7'd60)
            begin
                f = (b & c) | (b & d) | (c & d);
            end
            else
            begin
                f = b ^ c ^ d;
            end
            return f;
        end
    endfunction

endpackage

>>> rtl/sha1_front.sv
// Input queue: holds accepted items until the core takes them.
module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  logic [7:0]          data_byte,
    input  logic                byte_valid,
    input  logic                end_of_message,
    output logic                ready,
    output logic                q_valid,
    output sha1_pkg::sha1_item_t q_item,
    input  logic                q_take
);
    import sha1_pkg::*;

    sha1_item_t slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // Idle items are dropped here; they change nothing downstream.
    assign ready   = (count_reg != 2'(QUEUE_DEPTH));
    assign push    = valid && ready && (byte_valid || end_of_message);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign pop     = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data_byte, byte_valid, end_of_message};
        end
    end
endmodule

>>> rtl/sha1_message_digest.sv
// SHA-1 digest engine fed one message byte per item. Items whose byte_valid and
// end_of_message are both low are discarded; every other item is appended to the
// current message. At end of message the block pads the message, finishes the
// hash and delivers five result items (H0 first, last_word on H4), or a single
// result with too_long_error set if the 64-bit bit count wrapped. The engine then
// restarts by itself for the next message. A two-entry input queue separates the
// port from the compression core. A byte that does not complete a block is only
// written to the block window; one that completes a block also runs the rounds
// and the hash update, when the core takes no new item, so long messages are
// paced by the single shared round unit. End of message adds up to two block
// compressions, the padding sweep (one byte per cycle) and the result items.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        too_long_error
);
    import sha1_pkg::*;

    logic        front_ready;
    logic        q_valid;
    sha1_item_t  q_item;
    logic        q_take;

    // The front queue takes every offered item that is not idle while it has a free slot.
    sha1_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (valid),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_message(end_of_message),
        .ready         (front_ready),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_take        (q_take)
    );
    assign ready = front_ready;

    sha1_state_t state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [6:0]  round_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic        ovf_reg;
    logic        final_reg;
    logic [2:0]  emit_reg;
    logic        eom_pending_reg;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t_sum;
    logic [63:0] len_inc;
    logic [7:0]  pad_byte;

    // Round word: first 16 rounds use the loaded words, later ones expand.
    assign w_new = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                   | {31'd0, (w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31])};
    assign w_cur = (round_reg < 7'd16) ? w_reg[0] : w_new;
    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                   + e_reg + w_cur + round_k(round_reg);
    assign len_inc = len_reg + 64'd8;

    // Padding byte for the current fill position after 0x80: zeros, then the length once final_reg is set.
    always_comb
    begin
        if (fill_reg >= 6'd56 && !final_reg)
        begin
            pad_byte = 8'h00;
        end
        else if (fill_reg >= 6'd56)
        begin
            pad_byte = len_reg[8'(7 - fill_reg[2:0]) * 8 +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // final_reg: the 0x80 byte has been placed and the length fits in this block.
    logic pad_started_reg;

    assign q_take = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.byte_valid && !ovf_reg && fill_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (q_item.end_of_message)
                    begin
                        state_next = ovf_reg || (q_item.byte_valid && len_inc == 64'd0)
                                     ? ST_EMIT : ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (final_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (pad_started_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (eom_pending_reg)
                begin
                    state_next = ovf_reg ? ST_EMIT : ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && (emit_reg == 3'd4 || ovf_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid      = (state_reg == ST_EMIT);
        digest_word    = ovf_reg ? 32'd0 : h_reg[emit_reg];
        word_index     = ovf_reg ? 3'd0 : emit_reg;
        last_word      = ovf_reg || (emit_reg == 3'd4);
        too_long_error = ovf_reg;
    end

    // Byte insertion into the 16-word window (word 0 first, big-endian).
    logic        wr_byte;
    logic [7:0]  wr_val;
    always_comb
    begin
        wr_byte = 1'b0;
        wr_val  = pad_byte;
        if (state_reg == ST_IDLE && q_valid && q_item.byte_valid && !ovf_reg)
        begin
            wr_byte = 1'b1;
            wr_val  = q_item.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            wr_byte = 1'b1;
            wr_val  = pad_started_reg ? pad_byte : PAD_BYTE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_byte)
        begin
            w_reg[fill_reg[5:2]][8'(3 - fill_reg[1:0]) * 8 +: 8] <= wr_val;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
        end
        if (state_reg == ST_ROUND)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            h_reg           <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
            round_reg       <= 7'd0;
            fill_reg        <= 6'd0;
            len_reg         <= 64'd0;
            ovf_reg         <= 1'b0;
            final_reg       <= 1'b0;
            pad_started_reg <= 1'b0;
            emit_reg        <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    round_reg <= 7'd0;
                    if (q_valid && q_item.byte_valid && !ovf_reg)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        len_reg  <= len_inc;
                        if (len_inc == 64'd0)
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    if (q_valid && q_item.end_of_message && !ovf_reg
                        && !(q_item.byte_valid && len_inc == 64'd0))
                    begin
                        pad_started_reg <= 1'b0;
                    end
                    if (q_valid && q_item.end_of_message)
                    begin
                        emit_reg <= 3'd0;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    round_reg <= 7'd0;
                end
                ST_PAD:
                begin
                    fill_reg        <= fill_reg + 6'd1;
                    pad_started_reg <= 1'b1;
                    if (!pad_started_reg && fill_reg < 6'd56)
                    begin
                        final_reg <= 1'b1;
                    end
                    else if (pad_started_reg && fill_reg == 6'd55)
                    begin
                        final_reg <= 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (emit_reg == 3'd4 || ovf_reg)
                        begin
                            h_reg           <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
                            fill_reg        <= 6'd0;
                            len_reg         <= 64'd0;
                            ovf_reg         <= 1'b0;
                            final_reg       <= 1'b0;
                            pad_started_reg <= 1'b0;
                            emit_reg        <= 3'd0;
                        end
                        else
                        begin
                            emit_reg <= emit_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    round_reg <= 7'd0;
                end
            endcase
        end
    end

    // Pending end of message after a block-completing byte. The full block is
    // compressed first; the hash update then moves on to padding or the error result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eom_pending_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE && q_valid && q_item.byte_valid && !ovf_reg
                 && fill_reg == 6'd63 && q_item.end_of_message)
        begin
            eom_pending_reg <= 1'b1;
        end
        else if (state_reg == ST_ADD)
        begin
            eom_pending_reg <= 1'b0;
        end
    end
endmodule

>>> rtl/sha1_checker.sv
module sha1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word,
    input logic        too_long_error
);
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_index <= 3'd4)
        else $error("word index out of range");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !too_long_error |-> last_word == (word_index == 3'd4))
        else $error("last_word mismatch");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_long_error |-> last_word && word_index == 3'd0)
        else $error("error result malformed");
    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
        && $stable(word_index) && $stable(last_word) && $stable(too_long_error))
        else $error("result changed while stalled");
    // Digest words follow each other in order without a gap.
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid
        && word_index == $past(word_index) + 3'd1)
        else $error("digest words out of order");
endmodule

bind sha1_message_digest sha1_checker u_checker (.*);

>>> tb/sv/sha1_message_digest_tb.sv
module sha1_message_digest_tb;

    import sha1_pkg::*;

    // Clock, reset and the block's ports. Every input is driven to a known
    // value from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long_error;

    // One digest result as it appears on the output channel.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        too_long;
    } digest_result_t;

    // One row of the directed table. When has_known is set, the first digest
    // word of the message ended by this item is typed in and checked directly.
    typedef struct packed {
        logic [7:0]  data;
        logic        bvalid;
        logic        eom;
        logic        has_known;
        logic [31:0] known_h0;
    } stim_row_t;

    sha1_message_digest uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid          (valid),
        .ready          (ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .too_long_error (too_long_error)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: a private copy of the hash chaining words, the block
    // being filled, its fill level, the running bit count and the wrap flag.
    logic [31:0] chain_h [5];
    logic [7:0]  msg_block [64];
    int unsigned fill_count;
    logic [63:0] msg_bits;
    logic        bits_wrapped;

    digest_result_t expected_digests [$];
    int          fail_count = 0;
    longint      cycle_count = 0;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Start a new message with the standard initial chaining values.
    function automatic void start_message();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        fill_count = 0;
        msg_bits = '0;
        bits_wrapped = 1'b0;
    endfunction

    // Run the 80 rounds over msg_block and fold the result into chain_h.
    function automatic void compress_msg_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        fill_count = 0;
    endfunction

    // Apply one accepted item to the predictor and queue the results it causes.
    function automatic void predict_digest(input logic [7:0] data, input logic bvalid,
                                           input logic eom);
        digest_result_t r;
        if (bvalid && !bits_wrapped)
        begin
            msg_block[fill_count] = data;
            fill_count++;
            msg_bits += 64'd8;
            if (msg_bits == 64'd0)
            begin
                bits_wrapped = 1'b1;
            end
            if (fill_count == 64)
            begin
                compress_msg_block();
            end
        end
        if (!eom)
        begin
            return;
        end
        if (bits_wrapped)
        begin
            r = '{word: 32'd0, index: 3'd0, last: 1'b1, too_long: 1'b1};
            expected_digests.push_back(r);
        end
        else
        begin
            // Pad byte, zeros, then the big-endian bit count; an extra block
            // is needed when the pad leaves no room for the length.
            msg_block[fill_count] = PAD_BYTE;
            fill_count++;
            if (fill_count > 56)
            begin
                while (fill_count < 64)
                begin
                    msg_block[fill_count] = 8'h00;
                    fill_count++;
                end
                compress_msg_block();
            end
            while (fill_count < 56)
            begin
                msg_block[fill_count] = 8'h00;
                fill_count++;
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[56 + i] = msg_bits[63 - 8*i -: 8];
            end
            compress_msg_block();
            for (int j = 0; j < 5; j++)
            begin
                r = '{word: chain_h[j], index: 3'(j), last: (j == 4), too_long: 1'b0};
                expected_digests.push_back(r);
            end
        end
        start_message();
    endfunction

    // Sender burst control: a burst of random length, then a random gap.
    int burst_left = 0;

    // Valid stays high between items of a burst; it drops only for a gap or in idle_sender.
    task automatic send_item(input logic [7:0] data, input logic bvalid, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        valid <= 1'b1;
        data_byte <= data;
        byte_valid <= bvalid;
        end_of_message <= eom;
        do
        begin
            @(posedge clk);
        end
        while (!ready);
        predict_digest(data, bvalid, eom);
    endtask

    // Stop offering items; the next item starts a fresh burst.
    task automatic idle_sender();
        valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    // Known first words of standard test digests.
    localparam logic [31:0] EMPTY_H0 = 32'hDA39A3EE;
    localparam logic [31:0] ABC_H0   = 32'hA9993E36;

    // Checked as a directed expectation: the H0 result of a message ending
    // at a table row with a typed-in value.
    logic [31:0] known_h0_q [$];

    // Output side: stall on an irregular pattern, compare each result.
    always @(posedge clk)
    begin
        digest_result_t got;
        digest_result_t exp_r;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                got = '{word: digest_word, index: word_index, last: last_word,
                        too_long: too_long_error};
                if (expected_digests.size() == 0)
                begin
                    $display("%0t: unexpected result word %h index %0d", $time,
                             got.word, got.index);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_digests.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: result mismatch expected %h/%0d/%b/%b actual %h/%0d/%b/%b",
                                 $time, exp_r.word, exp_r.index, exp_r.last, exp_r.too_long,
                                 got.word, got.index, got.last, got.too_long);
                        fail_count++;
                    end
                    if (got.index == 3'd0 && !got.too_long && known_h0_q.size() > 0)
                    begin
                        if (known_h0_q[0] !== 32'hFFFFFFFF && got.word !== known_h0_q[0])
                        begin
                            $display("%0t: known digest mismatch expected %h actual %h",
                                     $time, known_h0_q[0], got.word);
                            fail_count++;
                        end
                        void'(known_h0_q.pop_front());
                    end
                end
            end
            // Stall pattern: long ready stretches mixed with random stalls.
            if (cycle_count[7:6] == 2'b11)
            begin
                out_ready <= ($urandom_range(0, 2) != 0);
            end
            else if (cycle_count[7:6] == 2'b10)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 4) != 0);
            end
        end
    end

    // Generous limit on the whole run, stalls included; reaching it fails the run.
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    stim_row_t directed [12] = '{
        // Idle item, then the empty message.
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_H0},
        // "abc", the last byte together with the end.
        '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_H0},
        // Extremes of the byte and an ignored byte, end on a separate item.
        '{8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hAA, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 32'h0},
        // A one-byte message ended with its byte, then an empty message whose byte is ignored.
        '{8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
        '{8'h01, 1'b0, 1'b1, 1'b1, EMPTY_H0}
    };

    initial
    begin
        int n_len;
        int n_msgs;
        start_message();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].has_known)
            begin
                known_h0_q.push_back(directed[i].known_h0);
            end
            else if (directed[i].eom)
            begin
                known_h0_q.push_back(32'hFFFFFFFF);
            end
            send_item(directed[i].data, directed[i].bvalid, directed[i].eom);
        end

        // Hold off until every digest so far has come out.
        idle_sender();
        while (expected_digests.size() != 0) @(posedge clk);

        // Messages of random length, many short and the rest around the block and padding boundaries,
        // with random content and a few idle items and stray flags mixed in.
        // The last message is cut short to keep the item count near the target.
        n_msgs = 0;
        for (int total = 0; total < 255; )
        begin
            case ($urandom_range(0, 5))
                0: n_len = $urandom_range(54, 57);
                1: n_len = $urandom_range(62, 66);
                2: n_len = $urandom_range(118, 130);
                default: n_len = $urandom_range(0, 12);
            endcase
            if (total + n_len >= 255)
            begin
                n_len = 254 - total;
            end
            for (int b = 0; b < n_len; b++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                end
                send_item(8'($urandom), 1'b1, 1'b0);
                total++;
            end
            known_h0_q.push_back(32'hFFFFFFFF);
            send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            total++;
            n_msgs++;
            if (n_msgs == 4)
            begin
                idle_sender();
                while (expected_digests.size() != 0) @(posedge clk);
            end
        end

        idle_sender();
        while (expected_digests.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && expected_digests.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
